// File: hw/rtl/length_crc32_deframer_assert.svh
// ----------------------------------------------------------------------------
// length_crc32_deframer_assert.svh
// Assertion macros for the length and CRC-32 deframer.
// ----------------------------------------------------------------------------
`ifndef LENGTH_CRC32_DEFRAMER_ASSERT_SVH
`define LENGTH_CRC32_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
// Next-cycle implication.
`define LCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define LCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/lcd_pkg.sv
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types, constants and CRC helpers of the length and CRC-32 deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd_pkg;

    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES    = 32'hFFFFFFFF;
    localparam logic [31:0] CAP_RESET   = 32'hFFFFFFFF;
    localparam logic [31:0] LEN_MAX     = 32'hFFFFFFF7;
    localparam logic [3:0]  MIN_FRAME   = 4'd8;
    localparam int          QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_LENGTH   = 3'd2,
        ST_CAPACITY = 3'd3,
        ST_CRC      = 3'd4
    } t_status;

    // One queue entry: the results caused by one accepted byte.
    typedef struct packed {
        logic       has_pay;
        logic       has_sts;
        logic [7:0] data;
        t_status    code;
    } t_entry;

    // Table entry of the reflected CRC-32, computed from the index bits.
    function automatic logic [31:0] crc_table(input logic [7:0] idx);
        logic [31:0] c;
        c = {24'd0, idx};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_update(input logic [31:0] crc,
                                               input logic [7:0]  b);
        return (crc >> 8) ^ crc_table(crc[7:0] ^ b);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/length_crc32_deframer.sv
// ----------------------------------------------------------------------------
// length_crc32_deframer
// Checks length-prefixed frames carrying a CRC-32 and forwards their payload.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle on the slave stream while its queue
// is not full, with tlast on the final byte. A frame is a 4-byte big-endian
// length L, L payload bytes, a 4-byte big-endian reflected CRC-32 of the
// payload (init and final xor all ones) and any number of ignored bytes. Each
// payload byte is passed out as it arrives when L is within the capacity
// register at that time. The final byte always yields one status request
// (tuser high, tlast high) carrying the code: ok, frame under 8 bytes, frame
// shorter than L plus 8, L above capacity, or CRC mismatch. Payload already
// sent is not recalled, so the consumer must drop it unless the status is ok.
// Sustained rate is one byte per cycle while the queue is not full; a final
// byte that is also a payload byte yields two output requests, which the
// output side sends one after the other while the parser keeps accepting into
// the queue. The parser updates the CRC with one table lookup per byte, which
// sets the critical path. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_crc32_deframer_assert.svh"

module length_crc32_deframer #(
    parameter int QUEUE_DEPTH = lcd_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // Capacity register write port.
    input  wire logic           i_cfg_wr_en,
    input  wire logic [31:0]    i_cfg_wr_data,
    // Frame byte stream.
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [7:0]     s_axis_tdata,   // [7:0] frame_byte
    input  wire logic           s_axis_tlast,   // frame_end
    // Result stream.
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [7:0] payload_byte, [10:8] status_code
    output logic                m_axis_tuser,   // item_kind
    output logic                m_axis_tlast    // last_of_frame
);

    // Receiving buffer capacity in payload bytes.
    logic [31:0]     r_out_capacity;

    lcd_pkg::t_entry q_wr_data;
    lcd_pkg::t_entry q_rd_data;
    logic            q_wr;
    logic            q_rd;
    logic            q_full;
    logic            q_empty;
    logic [7:0]      out_byte;
    logic [2:0]      out_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= lcd_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_out_capacity <= i_cfg_wr_data;
        end
    end

    // The parser runs the frame state and posts one entry per byte that has
    // any result; header and CRC bytes not at the frame end post nothing.
    lcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_end      (s_axis_tlast),
        .i_capacity (r_out_capacity),
        .i_full     (q_full),
        .o_push     (q_wr),
        .o_entry    (q_wr_data)
    );

    lcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    // The output side holds one entry and sends its payload request first,
    // then its status request.
    lcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (q_rd_data),
        .i_empty (q_empty),
        .o_rd    (q_rd),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_byte  (out_byte),
        .o_code  (out_code),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_code, out_byte};

    // The parser never posts into a full queue.
    `LCD_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, q_wr, !q_full)
    // Every accepted final byte leaves a status entry in the queue.
    `LCD_ASSERT_IMP(a_end_posts, i_clk, i_rst_n,
                    s_axis_tvalid && s_axis_tready && s_axis_tlast, q_wr)
    // The output side only pops when an entry is waiting.
    `LCD_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, q_rd, !q_empty)

endmodule

`default_nettype wire

// File: hw/rtl/lcd_front.sv
// ----------------------------------------------------------------------------
// lcd_front
// Frame parser: tracks header, payload and CRC fields and posts results.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_end,
    input  wire logic [31:0]    i_capacity,
    input  wire logic           i_full,
    output logic                o_push,
    output lcd_pkg::t_entry     o_entry
);

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_CRC     = 4'b0100,
        PH_TRAIL   = 4'b1000
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [31:0]    r_count, n_count;
    logic [3:0]     r_seen, n_seen;
    logic [31:0]    r_len, n_len;
    logic [31:0]    r_crc, n_crc;
    logic [31:0]    r_rx, n_rx;

    logic           accept;
    logic           pay;
    logic [32:0]    len_p4;
    logic [32:0]    len_p8;
    logic [32:0]    need;
    lcd_pkg::t_status code;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign len_p4  = {1'b0, r_len} + 33'd4;
    assign len_p8  = {1'b0, r_len} + 33'd8;

    always_comb begin
        n_phase = r_phase;
        n_count = (r_count == 32'hFFFFFFFF) ? r_count : r_count + 32'd1;
        n_seen  = (r_seen < lcd_pkg::MIN_FRAME) ? r_seen + 4'd1 : r_seen;
        n_len   = r_len;
        n_crc   = r_crc;
        n_rx    = r_rx;
        pay     = 1'b0;

        case (r_phase)
            PH_HEADER: begin
                n_len = {r_len[23:0], i_byte};
                if (n_count == 32'd4) begin
                    n_phase = (n_len == 32'd0) ? PH_CRC : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_crc = lcd_pkg::crc_update(r_crc, i_byte);
                pay   = (r_len <= i_capacity);
                if ({1'b0, n_count} == len_p4) begin
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                n_rx = {r_rx[23:0], i_byte};
                if ({1'b0, n_count} == len_p8) begin
                    n_phase = PH_TRAIL;
                end
            end
            PH_TRAIL: begin
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    // Status of the frame, judged on the state as it stands after this byte.
    assign need = {1'b0, n_len} + 33'd8;

    always_comb begin
        if (n_seen < lcd_pkg::MIN_FRAME) begin
            code = lcd_pkg::ST_SHORT;
        end else if (n_len > lcd_pkg::LEN_MAX) begin
            code = lcd_pkg::ST_LENGTH;
        end else if ({1'b0, n_count} < need) begin
            code = lcd_pkg::ST_LENGTH;
        end else if (n_len > i_capacity) begin
            code = lcd_pkg::ST_CAPACITY;
        end else if ((n_crc ^ lcd_pkg::CRC_ONES) != n_rx) begin
            code = lcd_pkg::ST_CRC;
        end else begin
            code = lcd_pkg::ST_OK;
        end
    end

    assign o_push          = accept && (pay || i_end);
    assign o_entry.has_pay = pay;
    assign o_entry.has_sts = i_end;
    assign o_entry.data    = i_byte;
    assign o_entry.code    = i_end ? code : lcd_pkg::ST_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= 32'd0;
            r_seen  <= 4'd0;
            r_len   <= 32'd0;
            r_crc   <= lcd_pkg::CRC_ONES;
            r_rx    <= 32'd0;
        end else if (accept) begin
            if (i_end) begin
                r_phase <= PH_HEADER;
                r_count <= 32'd0;
                r_seen  <= 4'd0;
                r_len   <= 32'd0;
                r_crc   <= lcd_pkg::CRC_ONES;
                r_rx    <= 32'd0;
            end else begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_seen  <= n_seen;
                r_len   <= n_len;
                r_crc   <= n_crc;
                r_rx    <= n_rx;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lcd_queue.sv
// ----------------------------------------------------------------------------
// lcd_queue
// Small first-word-fall-through queue between the parser and the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_queue #(
    parameter int DEPTH = lcd_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr,
    input  wire lcd_pkg::t_entry    i_data,
    output logic                    o_full,
    input  wire logic               i_rd,
    output lcd_pkg::t_entry         o_data,
    output logic                    o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lcd_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lcd_back.sv
// ----------------------------------------------------------------------------
// lcd_back
// Output stage: turns queue entries into payload and status stream items.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lcd_pkg::t_entry    i_entry,
    input  wire logic               i_empty,
    output logic                    o_rd,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_kind,
    output logic [7:0]              o_byte,
    output logic [2:0]              o_code,
    output logic                    o_last
);

    lcd_pkg::t_entry r_cur;
    logic            r_cur_valid;
    logic            r_pay_pend;

    logic fire;
    logic done;
    logic load;

    assign fire = r_cur_valid && i_ready;
    // An entry is finished once its last item (payload alone, or status) goes out.
    assign done = fire && (!r_pay_pend || !r_cur.has_sts);
    assign load = (!r_cur_valid || done) && !i_empty;
    assign o_rd = load;

    assign o_valid = r_cur_valid;
    assign o_kind  = !r_pay_pend;
    assign o_last  = !r_pay_pend;
    assign o_byte  = r_pay_pend ? r_cur.data : 8'd0;
    assign o_code  = r_pay_pend ? 3'(lcd_pkg::ST_OK) : 3'(r_cur.code);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_pay_pend  <= 1'b0;
        end else if (load) begin
            r_cur_valid <= 1'b1;
            r_pay_pend  <= i_entry.has_pay;
        end else if (done) begin
            r_cur_valid <= 1'b0;
            r_pay_pend  <= 1'b0;
        end else if (fire) begin
            r_pay_pend  <= 1'b0;
        end
    end

endmodule

`default_nettype wire
